[src/dq_pkg.sv]
`default_nettype none
package dq_pkg;

	// Number of entries the queue can hold.
	localparam int DEPTH = 16;
	localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	// Fixed field widths of the transactions.
	localparam int ACT_W  = 3;
	localparam int DATA_W = 32;
	localparam int STAT_W = 2;
	localparam int OCC_W  = 5;

	// Action codes.
	localparam logic [ACT_W-1:0] ACT_PUSH_FRONT = 3'd0;
	localparam logic [ACT_W-1:0] ACT_PUSH_BACK  = 3'd1;
	localparam logic [ACT_W-1:0] ACT_POP_FRONT  = 3'd2;
	localparam logic [ACT_W-1:0] ACT_POP_BACK   = 3'd3;
	localparam logic [ACT_W-1:0] ACT_SEARCH     = 3'd4;
	localparam logic [ACT_W-1:0] ACT_CLEAR      = 3'd5;

	// Status codes.
	localparam logic [STAT_W-1:0] STAT_OK    = 2'd0;
	localparam logic [STAT_W-1:0] STAT_EMPTY = 2'd1;
	localparam logic [STAT_W-1:0] STAT_FULL  = 2'd2;

	// Cell operation codes.
	localparam logic [1:0] CELL_HOLD = 2'd0;
	localparam logic [1:0] CELL_SHR  = 2'd1;
	localparam logic [1:0] CELL_SHL  = 2'd2;
	localparam logic [1:0] CELL_LOAD = 2'd3;

	// Control broadcast to every cell.
	typedef struct packed {
		logic [1:0]              op;
		logic [CNT_W-1:0]        count;
		logic signed [DATA_W-1:0] wdata;
		logic signed [DATA_W-1:0] key;
	} cell_ctrl_t;

	// Probe token that walks from cell to cell.
	typedef struct packed {
		logic                     valid;
		logic                     hit;
		logic signed [DATA_W-1:0] data;
	} probe_t;

endpackage
`default_nettype wire

[src/dq_cell.sv]
`default_nettype none
module dq_cell (
	input  wire                            clk,
	input  wire                            arst_n,
	input  wire  [dq_pkg::IDX_W-1:0]       index,
	input  wire  dq_pkg::cell_ctrl_t       ctrl,
	input  wire  signed [dq_pkg::DATA_W-1:0] left_data,
	input  wire  signed [dq_pkg::DATA_W-1:0] right_data,
	output logic signed [dq_pkg::DATA_W-1:0] data,
	input  wire  dq_pkg::probe_t           probe_in,
	output dq_pkg::probe_t                 probe_out
);
	import dq_pkg::*;

	logic signed [DATA_W-1:0] data_q;
	logic                     pvalid_q;
	logic                     phit_q;
	logic signed [DATA_W-1:0] pdata_q;
	logic                     occupied;
	logic                     is_last;
	logic                     is_tail;
	logic                     match;

	assign occupied = CNT_W'(index) < ctrl.count;
	assign is_last  = CNT_W'(index) == (ctrl.count - CNT_W'(1));
	assign is_tail  = CNT_W'(index) == ctrl.count;
	assign match    = probe_in.valid & occupied & (data_q == ctrl.key);

	always_ff @(posedge clk) begin
		case (ctrl.op)
			CELL_SHR: data_q <= left_data;
			CELL_SHL: data_q <= right_data;
			CELL_LOAD: begin
				if (is_tail) begin
					data_q <= ctrl.wdata;
				end
			end
			default: data_q <= data_q;
		endcase
	end

	// The token picks up a hit and, at the last occupied cell, that cell's word.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pvalid_q <= 1'b0;
		end else begin
			pvalid_q <= probe_in.valid;
		end
	end

	always_ff @(posedge clk) begin
		phit_q  <= probe_in.hit | match;
		pdata_q <= (probe_in.valid && is_last) ? data_q : probe_in.data;
	end

	assign data      = data_q;
	assign probe_out = '{valid: pvalid_q, hit: phit_q, data: pdata_q};

endmodule
`default_nettype wire

[src/deque_with_search_unit.sv]
// Push front, push back, pop front, clear, unused codes, and search or pop
// back on an empty queue: a registered result in the cycle after accept; a
// new transaction every cycle unless in_stall holds it off. Other searches
// and pop backs walk a token from start_q down the DEPTH cells, one at a time.
// Reset (arst_n low, asynchronous) empties the queue and drops any result.
`default_nettype none
module deque_with_search_unit (
	input  wire                             clk,
	input  wire                             arst_n,
	input  wire                             in_valid,
	output logic                            in_stall,
	input  wire  [dq_pkg::ACT_W-1:0]        action,
	input  wire  signed [dq_pkg::DATA_W-1:0] value,
	output logic                            out_valid,
	input  wire                             out_stall,
	output logic [dq_pkg::STAT_W-1:0]       status,
	output logic signed [dq_pkg::DATA_W-1:0] popped,
	output logic                            found,
	output logic [dq_pkg::OCC_W-1:0]        occupancy
);
	import dq_pkg::*;

	// Controller states: either ready for a transaction or waiting on a probe.
	localparam logic S_IDLE  = 1'b0;
	localparam logic S_PROBE = 1'b1;

	logic                     state_q;
	logic [ACT_W-1:0]         act_q;
	logic signed [DATA_W-1:0] key_q;
	logic                     start_q;
	logic [CNT_W-1:0]         count_q;

	logic                     out_valid_q;
	logic [STAT_W-1:0]        status_q;
	logic signed [DATA_W-1:0] popped_q;
	logic                     found_q;
	logic [OCC_W-1:0]         occ_q;

	logic                     accept;
	logic                     full;
	logic                     empty;
	logic                     launch;
	logic                     imm_res;
	logic [STAT_W-1:0]        imm_status;
	logic signed [DATA_W-1:0] imm_popped;
	logic [CNT_W-1:0]         imm_count;
	logic                     probe_done;
	logic [CNT_W-1:0]         done_count;

	cell_ctrl_t               ctrl;
	logic signed [DATA_W-1:0] cell_data [DEPTH];
	logic signed [DATA_W-1:0] left_in   [DEPTH];
	logic signed [DATA_W-1:0] right_in  [DEPTH];
	probe_t                   probe     [DEPTH+1];

	// The input side is held off while a probe is walking the chain, or while
	// the output register holds a result that the receiver has not taken.
	assign in_stall = (state_q != S_IDLE) | (out_valid_q & out_stall);
	assign accept   = in_valid & ~in_stall;
	assign full     = count_q == CNT_W'(DEPTH);
	assign empty    = count_q == '0;

	// Decode an accepted transaction. Cells are kept front aligned: cell 0 is
	// always the front entry, so a push front or pop front moves the whole row
	// by one place, and a push back loads the cell just past the last entry.
	always_comb begin
		ctrl.op    = CELL_HOLD;
		ctrl.count = count_q;
		ctrl.wdata = value;
		ctrl.key   = key_q;
		launch     = 1'b0;
		imm_res    = 1'b0;
		imm_status = STAT_OK;
		imm_popped = '0;
		imm_count  = count_q;
		if (accept) begin
			imm_res = 1'b1;
			case (action)
				ACT_PUSH_FRONT: begin
					if (full) begin
						imm_status = STAT_FULL;
					end else begin
						ctrl.op   = CELL_SHR;
						imm_count = count_q + CNT_W'(1);
					end
				end
				ACT_PUSH_BACK: begin
					if (full) begin
						imm_status = STAT_FULL;
					end else begin
						ctrl.op   = CELL_LOAD;
						imm_count = count_q + CNT_W'(1);
					end
				end
				ACT_POP_FRONT: begin
					if (empty) begin
						imm_status = STAT_EMPTY;
					end else begin
						ctrl.op    = CELL_SHL;
						imm_popped = cell_data[0];
						imm_count  = count_q - CNT_W'(1);
					end
				end
				ACT_POP_BACK: begin
					if (empty) begin
						imm_status = STAT_EMPTY;
					end else begin
						imm_res = 1'b0;
						launch  = 1'b1;
					end
				end
				ACT_SEARCH: begin
					// An empty queue answers not found at once.
					if (!empty) begin
						imm_res = 1'b0;
						launch  = 1'b1;
					end
				end
				ACT_CLEAR: imm_count = '0;
				default: imm_count = count_q;
			endcase
		end
	end

	// Neighbor wiring: the push value enters at the front, and the last cell
	// keeps its own word on a left shift.
	assign probe[0] = '{valid: start_q, hit: 1'b0, data: '0};

	for (genvar k = 0; k < DEPTH; k++) begin : g_cell
		if (k == 0) begin : g_first
			assign left_in[k] = value;
		end else begin : g_mid
			assign left_in[k] = cell_data[k-1];
		end
		if (k == DEPTH - 1) begin : g_last
			assign right_in[k] = cell_data[k];
		end else begin : g_rest
			assign right_in[k] = cell_data[k+1];
		end

		dq_cell u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.index     (IDX_W'(k)),
			.ctrl      (ctrl),
			.left_data (left_in[k]),
			.right_data(right_in[k]),
			.data      (cell_data[k]),
			.probe_in  (probe[k]),
			.probe_out (probe[k+1])
		);
	end

	// The token leaves the last cell carrying the search hit and the word of
	// the last occupied cell; a pop back then shortens the queue by one.
	assign probe_done = (state_q == S_PROBE) & probe[DEPTH].valid;
	assign done_count = (act_q == ACT_POP_BACK) ? count_q - CNT_W'(1) : count_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			start_q     <= 1'b0;
			count_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			start_q <= launch;
			if (launch) begin
				state_q <= S_PROBE;
			end else if (probe_done) begin
				state_q <= S_IDLE;
			end
			if (imm_res) begin
				count_q <= imm_count;
			end else if (probe_done) begin
				count_q <= done_count;
			end
			if (imm_res || probe_done) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Transaction payload registers.
	always_ff @(posedge clk) begin
		if (launch) begin
			act_q <= action;
			key_q <= value;
		end
		if (imm_res) begin
			status_q <= imm_status;
			popped_q <= imm_popped;
			found_q  <= 1'b0;
			occ_q    <= OCC_W'(imm_count);
		end else if (probe_done) begin
			status_q <= STAT_OK;
			popped_q <= (act_q == ACT_POP_BACK) ? probe[DEPTH].data : '0;
			found_q  <= (act_q == ACT_SEARCH) & probe[DEPTH].hit;
			occ_q    <= OCC_W'(done_count);
		end
	end

	assign out_valid = out_valid_q;
	assign status    = status_q;
	assign popped    = popped_q;
	assign found     = found_q;
	assign occupancy = occ_q;

endmodule
`default_nettype wire

[src/dq_checker.sv]
`default_nettype none
module dq_checker (
	input wire                              clk,
	input wire                              arst_n,
	input wire                              in_valid,
	input wire                              in_stall,
	input wire  [dq_pkg::ACT_W-1:0]         action,
	input wire  signed [dq_pkg::DATA_W-1:0] value,
	input wire                              out_valid,
	input wire                              out_stall,
	input wire  [dq_pkg::STAT_W-1:0]        status,
	input wire  signed [dq_pkg::DATA_W-1:0] popped,
	input wire                              found,
	input wire  [dq_pkg::OCC_W-1:0]         occupancy
);
	import dq_pkg::*;

	// A stalled result stays put.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(status) && $stable(popped)
			&& $stable(found) && $stable(occupancy))
		else $error("stalled result changed");

	// A pop on an empty queue reports nothing popped and an empty queue.
	a_empty_pop: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status == STAT_EMPTY |-> popped == '0 && occupancy == '0 && !found)
		else $error("empty status with data or entries");

	// A full report only comes with a full queue.
	a_full_push: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status == STAT_FULL |-> occupancy == OCC_W'(DEPTH) && popped == '0)
		else $error("full status without a full queue");

	// A hit is never reported on an empty queue or with a popped word.
	a_found: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && found |-> status == STAT_OK && popped == '0 && occupancy != '0)
		else $error("found flag with inconsistent result");

	// Status only ever takes one of its three codes.
	a_status: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> status == STAT_OK || status == STAT_EMPTY || status == STAT_FULL)
		else $error("undefined status code");

	logic unused_in;
	assign unused_in = in_valid ^ in_stall ^ (^action) ^ (^value);

endmodule

bind deque_with_search_unit dq_checker u_dq_checker (.*);
`default_nettype wire
